// File: rtl/fsp_pkg.sv
// shared constants, register map and reset values for the fan speed controller
package fsp_pkg;

    // default timer periods
    localparam int unsigned CAPTURE_PERIOD_DEF = 3000;
    localparam int unsigned PWM_PERIOD_DEF     = 1000;

    // field widths
    localparam int unsigned KIND_W    = 2;
    localparam int unsigned CAP_W     = 12;
    localparam int unsigned PWM_W     = 10;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned SPEED_W   = 18;
    localparam int unsigned TARGET_W  = 14;
    localparam int unsigned DUTY_W    = 7;
    localparam int unsigned CMP_W     = 10;
    localparam int unsigned STEP_W    = 12;
    localparam int unsigned HOLD_W    = 16;
    localparam int unsigned GAIN_W    = 16;

    // apb
    localparam int unsigned ADDR_W    = 5;
    localparam int unsigned DATA_W    = 32;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_CAPTURE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BUTTON  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK    = 2'd2;

    // register indexes
    localparam logic [2:0] REG_GATE_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_SPEED_MAX      = 3'd1;
    localparam logic [2:0] REG_SPEED_STEP     = 3'd2;
    localparam logic [2:0] REG_HOLDOFF_MS     = 3'd3;
    localparam logic [2:0] REG_GAIN_DIVISOR   = 3'd4;
    localparam logic [2:0] REG_DUTY_MAX       = 3'd5;

    // register reset values
    localparam logic [PWM_W-1:0]    GATE_RST = 10'd75;
    localparam logic [TARGET_W-1:0] SMAX_RST = 14'd9000;
    localparam logic [STEP_W-1:0]   STEP_RST = 12'd250;
    localparam logic [HOLD_W-1:0]   HOLD_RST = 16'd150;
    localparam logic [GAIN_W-1:0]   GAIN_RST = 16'd200;
    localparam logic [DUTY_W-1:0]   DMAX_RST = 7'd100;

    localparam int unsigned SPEED_SAT   = 262143;
    localparam int unsigned CMP_SAT     = 1023;
    localparam int unsigned DUTY_LIMIT  = 100;
    localparam int unsigned PERCENT     = 100;
    localparam int unsigned SEC_PER_MIN = 60;

endpackage

// File: rtl/fsp_serdiv.sv
// restoring divider, one quotient bit per cycle
module fsp_serdiv
    import fsp_pkg::*;
#(
    parameter int unsigned NUM_W = 18,
    parameter int unsigned DEN_W = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    localparam int unsigned CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   trial_sub;
    logic             fits;

    // dividend shifts out on top, quotient bits shift in at the bottom
    always_comb begin
        trial     = {rem_reg, num_reg[NUM_W-1]};
        trial_sub = trial - {1'b0, den_reg};
        fits      = trial >= {1'b0, den_reg};
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            num_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            num_next = {num_reg[NUM_W-2:0], fits};
            rem_next = fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = num_reg;

endmodule

// File: rtl/fan_speed_p_controller_core.sv
// Fan speed regulator: tachometer speed measurement, button target steps and a
// proportional duty loop, with an APB register port. Every accepted word returns one
// result word. A button press, a gated-off or first capture, or an unknown kind needs no
// division; a capture that measures speed and a control tick use the shared bit-serial
// divider, which is 18 bits wide at the default periods. The divider retires one quotient
// bit per cycle and serves the speed division, the gain division and the compare scaling
// in turn. A new word is accepted while the previous result still waits on the output
// register.
module fan_speed_p_controller_core
    import fsp_pkg::*;
#(
    parameter int unsigned CAPTURE_PERIOD = CAPTURE_PERIOD_DEF,
    parameter int unsigned PWM_PERIOD     = PWM_PERIOD_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    // apb
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    // input words
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [KIND_W-1:0]   s_kind,
    input  logic [CAP_W-1:0]    s_capture_value,
    input  logic [PWM_W-1:0]    s_pwm_count,
    input  logic                s_button_down,
    input  logic [TIME_W-1:0]   s_now_ms,
    // result words
    output logic                m_valid,
    input  logic                m_ready,
    output logic [SPEED_W-1:0]  m_measured_speed,
    output logic [TARGET_W-1:0] m_target_speed,
    output logic [DUTY_W-1:0]   m_duty_percent,
    output logic [CMP_W-1:0]    m_pwm_compare,
    output logic                m_capture_used
);

    localparam int unsigned EL_W      = $clog2(CAPTURE_PERIOD + (1 << CAP_W));
    localparam int unsigned DEN_W     = (EL_W > GAIN_W) ? EL_W : GAIN_W;
    localparam int unsigned SPD_NUM   = CAPTURE_PERIOD * SEC_PER_MIN;
    localparam int unsigned SPD_NUM_W = $clog2(SPD_NUM + 1);
    localparam int unsigned PROD_W    = $clog2(PWM_PERIOD * DUTY_LIMIT + 1);
    localparam int unsigned NW0       = (SPD_NUM_W > SPEED_W) ? SPD_NUM_W : SPEED_W;
    localparam int unsigned NUM_W     = (NW0 > PROD_W) ? NW0 : PROD_W;
    localparam int unsigned CMP_HALF  = PWM_PERIOD / 2;
    localparam logic [CMP_W-1:0] CMP_RST =
        CMP_W'((CMP_HALF > CMP_SAT) ? CMP_SAT : CMP_HALF);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_CAP_DIV  = 3'd1;
    localparam logic [2:0] ST_TICK_DIV = 3'd2;
    localparam logic [2:0] ST_TICK_MUL = 3'd3;
    localparam logic [2:0] ST_CMP_DIV  = 3'd4;
    localparam logic [2:0] ST_DONE     = 3'd5;

    // configuration
    logic [PWM_W-1:0]    gate_threshold_reg;
    logic [TARGET_W-1:0] speed_max_reg;
    logic [STEP_W-1:0]   speed_step_reg;
    logic [HOLD_W-1:0]   holdoff_ms_reg;
    logic [GAIN_W-1:0]   gain_divisor_reg;
    logic [DUTY_W-1:0]   duty_max_reg;
    logic                cfg_write;
    logic [2:0]          cfg_index;

    // controller state
    logic [2:0]          state_reg, state_next;
    logic [CAP_W-1:0]    last_capture_reg, last_capture_next;
    logic                capture_valid_reg, capture_valid_next;
    logic [SPEED_W-1:0]  speed_reg, speed_next;
    logic [TARGET_W-1:0] target_reg, target_next;
    logic [TIME_W-1:0]   last_press_reg, last_press_next;
    logic [DUTY_W-1:0]   duty_reg, duty_next;
    logic [CMP_W-1:0]    compare_reg, compare_next;
    logic                used_reg, used_next;
    logic                err_neg_reg, err_neg_next;

    // output register
    logic                m_valid_reg, m_valid_next;
    logic [SPEED_W-1:0]  out_speed_reg;
    logic [TARGET_W-1:0] out_target_reg;
    logic [DUTY_W-1:0]   out_duty_reg;
    logic [CMP_W-1:0]    out_compare_reg;
    logic                out_used_reg;
    logic                out_load;

    // divider
    logic                div_start;
    logic [NUM_W-1:0]    div_num;
    logic [DEN_W-1:0]    div_den;
    logic                div_done;
    logic [NUM_W-1:0]    div_q;

    // datapath
    logic                accept;
    logic                gate_ok;
    logic signed [EL_W:0] elapsed;
    logic                elapsed_pos;
    logic [TIME_W-1:0]   since_press;
    logic [TARGET_W:0]   target_up;
    logic signed [SPEED_W:0] err;
    logic [SPEED_W-1:0]  err_mag;
    logic [GAIN_W-1:0]   gain_eff;
    logic [DUTY_W-1:0]   duty_lim;
    logic [NUM_W:0]      duty_cand;
    logic [NUM_W-1:0]    product;

    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[4:2];
    assign pready    = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gate_threshold_reg <= GATE_RST;
            speed_max_reg      <= SMAX_RST;
            speed_step_reg     <= STEP_RST;
            holdoff_ms_reg     <= HOLD_RST;
            gain_divisor_reg   <= GAIN_RST;
            duty_max_reg       <= DMAX_RST;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_GATE_THRESHOLD: gate_threshold_reg <= pwdata[PWM_W-1:0];
                REG_SPEED_MAX:      speed_max_reg      <= pwdata[TARGET_W-1:0];
                REG_SPEED_STEP:     speed_step_reg     <= pwdata[STEP_W-1:0];
                REG_HOLDOFF_MS:     holdoff_ms_reg     <= pwdata[HOLD_W-1:0];
                REG_GAIN_DIVISOR:   gain_divisor_reg   <= pwdata[GAIN_W-1:0];
                REG_DUTY_MAX:       duty_max_reg       <= pwdata[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            REG_GATE_THRESHOLD: prdata = DATA_W'(gate_threshold_reg);
            REG_SPEED_MAX:      prdata = DATA_W'(speed_max_reg);
            REG_SPEED_STEP:     prdata = DATA_W'(speed_step_reg);
            REG_HOLDOFF_MS:     prdata = DATA_W'(holdoff_ms_reg);
            REG_GAIN_DIVISOR:   prdata = DATA_W'(gain_divisor_reg);
            REG_DUTY_MAX:       prdata = DATA_W'(duty_max_reg);
            default:            prdata = '0;
        endcase
    end

    fsp_serdiv #(
        .NUM_W(NUM_W),
        .DEN_W(DEN_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    always_comb begin
        gate_ok = (s_pwm_count > gate_threshold_reg) && (s_pwm_count < compare_reg);
        if (s_capture_value > last_capture_reg) begin
            elapsed = $signed({1'b0, EL_W'(s_capture_value)})
                    - $signed({1'b0, EL_W'(last_capture_reg)});
        end else begin
            elapsed = $signed({1'b0, EL_W'(CAPTURE_PERIOD)})
                    - $signed({1'b0, EL_W'(last_capture_reg)})
                    + $signed({1'b0, EL_W'(s_capture_value)});
        end
        elapsed_pos = !elapsed[EL_W] && (elapsed != '0);
        since_press = s_now_ms - last_press_reg;
        target_up   = {1'b0, target_reg} + (TARGET_W+1)'(speed_step_reg);
        err         = $signed({(SPEED_W+1-TARGET_W)'(0), target_reg})
                    - $signed({1'b0, speed_reg});
        err_mag     = err[SPEED_W] ? SPEED_W'(-err) : err[SPEED_W-1:0];
        gain_eff    = (gain_divisor_reg == '0) ? GAIN_W'(1) : gain_divisor_reg;
        duty_lim    = (duty_max_reg > DUTY_W'(DUTY_LIMIT)) ? DUTY_W'(DUTY_LIMIT)
                                                           : duty_max_reg;
        // negative steps stop at zero, then both directions clamp to the limit
        if (err_neg_reg) begin
            duty_cand = (div_q >= NUM_W'(duty_reg)) ? '0
                      : (NUM_W+1)'(duty_reg - div_q[DUTY_W-1:0]);
        end else begin
            duty_cand = (NUM_W+1)'(duty_reg) + (NUM_W+1)'(div_q);
        end
        product = NUM_W'(PROD_W'(PWM_PERIOD) * PROD_W'(duty_reg));
    end

    always_comb begin
        state_next         = state_reg;
        last_capture_next  = last_capture_reg;
        capture_valid_next = capture_valid_reg;
        speed_next         = speed_reg;
        target_next        = target_reg;
        last_press_next    = last_press_reg;
        duty_next          = duty_reg;
        compare_next       = compare_reg;
        used_next          = used_reg;
        err_neg_next       = err_neg_reg;
        div_start          = 1'b0;
        div_num            = NUM_W'(err_mag);
        div_den            = DEN_W'(gain_eff);
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    used_next  = 1'b0;
                    state_next = ST_DONE;
                    case (s_kind)
                        KIND_CAPTURE: begin
                            if (gate_ok) begin
                                last_capture_next = s_capture_value;
                                if (!capture_valid_reg) begin
                                    capture_valid_next = 1'b1;
                                end else if (elapsed_pos) begin
                                    div_start  = 1'b1;
                                    div_num    = NUM_W'(SPD_NUM);
                                    div_den    = DEN_W'(elapsed[EL_W-1:0]);
                                    state_next = ST_CAP_DIV;
                                end
                            end else begin
                                capture_valid_next = 1'b0;
                            end
                        end
                        KIND_BUTTON: begin
                            if (since_press > TIME_W'(holdoff_ms_reg)) begin
                                last_press_next = s_now_ms;
                                if (!s_button_down) begin
                                    if (target_up <= {1'b0, speed_max_reg}) begin
                                        target_next = target_up[TARGET_W-1:0];
                                    end
                                end else if (target_reg >= TARGET_W'(speed_step_reg)) begin
                                    target_next = target_reg - TARGET_W'(speed_step_reg);
                                end
                            end
                        end
                        KIND_TICK: begin
                            err_neg_next = err[SPEED_W];
                            div_start    = 1'b1;
                            state_next   = ST_TICK_DIV;
                        end
                        default: ;
                    endcase
                end
            end
            ST_CAP_DIV: begin
                if (div_done) begin
                    speed_next = (div_q > NUM_W'(SPEED_SAT)) ? SPEED_W'(SPEED_SAT)
                                                             : div_q[SPEED_W-1:0];
                    used_next  = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_TICK_DIV: begin
                if (div_done) begin
                    duty_next  = (duty_cand > (NUM_W+1)'(duty_lim)) ? duty_lim
                                                                     : duty_cand[DUTY_W-1:0];
                    state_next = ST_TICK_MUL;
                end
            end
            ST_TICK_MUL: begin
                div_start  = 1'b1;
                div_num    = product;
                div_den    = DEN_W'(PERCENT);
                state_next = ST_CMP_DIV;
            end
            ST_CMP_DIV: begin
                if (div_done) begin
                    compare_next = (div_q > NUM_W'(CMP_SAT)) ? CMP_W'(CMP_SAT)
                                                             : div_q[CMP_W-1:0];
                    state_next   = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (out_load) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            last_capture_reg  <= '0;
            capture_valid_reg <= 1'b1;
            speed_reg         <= '0;
            target_reg        <= '0;
            last_press_reg    <= '0;
            duty_reg          <= '0;
            compare_reg       <= CMP_RST;
            used_reg          <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg         <= state_next;
            last_capture_reg  <= last_capture_next;
            capture_valid_reg <= capture_valid_next;
            speed_reg         <= speed_next;
            target_reg        <= target_next;
            last_press_reg    <= last_press_next;
            duty_reg          <= duty_next;
            compare_reg       <= compare_next;
            used_reg          <= used_next;
            m_valid_reg       <= m_valid_next;
        end
        err_neg_reg <= err_neg_next;
        if (out_load) begin
            out_speed_reg   <= speed_reg;
            out_target_reg  <= target_reg;
            out_duty_reg    <= duty_reg;
            out_compare_reg <= compare_reg;
            out_used_reg    <= used_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_measured_speed = out_speed_reg;
    assign m_target_speed   = out_target_reg;
    assign m_duty_percent   = out_duty_reg;
    assign m_pwm_compare    = out_compare_reg;
    assign m_capture_used   = out_used_reg;

endmodule

// File: tb/fan_speed_p_controller_core_test.sv
// self-checking testbench for the fan speed regulator core: directed table, then random phases
`timescale 1ns / 1ps

module fan_speed_p_controller_core_test;
    import fsp_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int N_DIRECTED      = 25;
    localparam int N_SETS          = 6;
    localparam int RANDOM_SET      = 4;
    localparam int WORDS_PER_PHASE = 275;
    localparam int DRAIN_CYCLES    = 60;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CAP_W-1:0]  capture;
        logic [PWM_W-1:0]  pwm;
        logic              down;
        logic [TIME_W-1:0] now;
    } fan_event_t;

    typedef struct packed {
        logic [SPEED_W-1:0]  speed;
        logic [TARGET_W-1:0] target;
        logic [DUTY_W-1:0]   duty;
        logic [CMP_W-1:0]    compare;
        logic                used;
    } fan_status_t;

    typedef struct packed {
        fan_event_t  ev;
        logic        typed;
        fan_status_t status;
    } directed_row_t;

    typedef struct packed {
        logic [PWM_W-1:0]    gate;
        logic [TARGET_W-1:0] smax;
        logic [STEP_W-1:0]   step;
        logic [HOLD_W-1:0]   hold;
        logic [GAIN_W-1:0]   gain;
        logic [DUTY_W-1:0]   dmax;
    } cfg_set_t;

    // runs at reset settings; typed rows carry their expected status
    localparam directed_row_t DIRECTED [N_DIRECTED] = '{
        '{'{KIND_UNKNOWN, 4095, 1023, 1, 32'hFFFF_FFFF}, 1, '{0, 0, 0, 500, 0}},
        '{'{KIND_CAPTURE, 600, 100, 0, 0}, 1, '{300, 0, 0, 500, 1}},
        '{'{KIND_CAPTURE, 0, 100, 0, 0}, 0, '0},
        '{'{KIND_CAPTURE, 1, 100, 0, 0}, 1, '{180000, 0, 0, 500, 1}},
        '{'{KIND_CAPTURE, 2999, 499, 0, 0}, 0, '0},
        '{'{KIND_CAPTURE, 2999, 76, 0, 0}, 0, '0},
        '{'{KIND_CAPTURE, 4095, 100, 0, 0}, 0, '0},
        '{'{KIND_CAPTURE, 1095, 100, 0, 0}, 0, '0},
        '{'{KIND_CAPTURE, 4095, 100, 0, 0}, 0, '0},
        '{'{KIND_CAPTURE, 0, 100, 0, 0}, 0, '0},
        '{'{KIND_CAPTURE, 123, 75, 0, 0}, 0, '0},
        '{'{KIND_CAPTURE, 456, 500, 0, 0}, 0, '0},
        '{'{KIND_CAPTURE, 1023, 0, 0, 0}, 0, '0},
        '{'{KIND_CAPTURE, 1500, 1023, 0, 0}, 0, '0},
        '{'{KIND_CAPTURE, 2000, 300, 0, 0}, 0, '0},
        '{'{KIND_CAPTURE, 2500, 300, 0, 0}, 0, '0},
        '{'{KIND_BUTTON, 0, 0, 0, 150}, 0, '0},
        '{'{KIND_BUTTON, 0, 0, 0, 151}, 0, '0},
        '{'{KIND_BUTTON, 0, 0, 0, 301}, 0, '0},
        '{'{KIND_BUTTON, 0, 0, 0, 302}, 0, '0},
        '{'{KIND_TICK, 0, 0, 0, 0}, 0, '0},
        '{'{KIND_BUTTON, 0, 0, 1, 0}, 0, '0},
        '{'{KIND_BUTTON, 0, 0, 1, 32'hFFFF_FFFF}, 0, '0},
        '{'{KIND_BUTTON, 0, 0, 1, 32'h7FFF_FFFF}, 0, '0},
        '{'{KIND_TICK, 4095, 1023, 1, 32'hFFFF_FFFF}, 0, '0}
    };

    // the random set is drawn at run time
    localparam cfg_set_t CFG_SETS [N_SETS] = '{
        '{0, 16383, 4095, 0, 1, 100},
        '{1023, 0, 1, 65535, 65535, 0},
        '{200, 12000, 700, 10, 50, 80},
        '{75, 9000, 250, 150, 0, 127},
        '{0, 0, 1, 0, 1, 0},
        '{10, 3000, 100, 1, 7, 60}
    };

    logic                aclk;
    logic                aresetn         = 1'b0;
    logic                psel            = 1'b0;
    logic                penable         = 1'b0;
    logic                pwrite          = 1'b0;
    logic [ADDR_W-1:0]   paddr           = '0;
    logic [DATA_W-1:0]   pwdata          = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                s_valid         = 1'b0;
    logic                s_ready;
    logic [KIND_W-1:0]   s_kind          = '0;
    logic [CAP_W-1:0]    s_capture_value = '0;
    logic [PWM_W-1:0]    s_pwm_count     = '0;
    logic                s_button_down   = 1'b0;
    logic [TIME_W-1:0]   s_now_ms        = '0;
    logic                m_valid;
    logic                m_ready         = 1'b0;
    logic [SPEED_W-1:0]  m_measured_speed;
    logic [TARGET_W-1:0] m_target_speed;
    logic [DUTY_W-1:0]   m_duty_percent;
    logic [CMP_W-1:0]    m_pwm_compare;
    logic                m_capture_used;

    // regulator state as the block should hold it
    logic [PWM_W-1:0]    gate_cfg      = GATE_RST;
    logic [TARGET_W-1:0] smax_cfg      = SMAX_RST;
    logic [STEP_W-1:0]   step_cfg      = STEP_RST;
    logic [HOLD_W-1:0]   hold_cfg      = HOLD_RST;
    logic [GAIN_W-1:0]   gain_cfg      = GAIN_RST;
    logic [DUTY_W-1:0]   dmax_cfg      = DMAX_RST;
    logic [CAP_W-1:0]    last_capture  = '0;
    logic                capture_armed = 1'b1;
    logic [SPEED_W-1:0]  speed_now     = '0;
    logic [TARGET_W-1:0] target_now    = '0;
    logic [TIME_W-1:0]   press_ms      = '0;
    logic [DUTY_W-1:0]   duty_now      = '0;
    logic [CMP_W-1:0]    compare_now   = CMP_W'(PWM_PERIOD_DEF / 2);

    fan_status_t pending_status [$];
    int          mismatches  = 0;
    int          cycle_count = 0;
    bit          tx_calm     = 1'b0;
    bit          rx_calm     = 1'b0;

    fan_speed_p_controller_core i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_capture_value  (s_capture_value),
        .s_pwm_count      (s_pwm_count),
        .s_button_down    (s_button_down),
        .s_now_ms         (s_now_ms),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_measured_speed (m_measured_speed),
        .m_target_speed   (m_target_speed),
        .m_duty_percent   (m_duty_percent),
        .m_pwm_compare    (m_pwm_compare),
        .m_capture_used   (m_capture_used)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[fan_speed_p_controller_core] ERROR");
            $finish;
        end
    end

    // idle stretches come and go so some runs of words see no gaps at all
    function automatic int pick_gap(inout bit calm);
        if ($urandom_range(0, 31) == 0) calm = !calm;
        return calm ? 0 : $urandom_range(0, 18);
    endfunction

    // advance the regulator by one word and return the status it reports
    function automatic fan_status_t regulate_fan(input fan_event_t ev);
        fan_status_t       st;
        int                elapsed;
        int                err;
        int                divisor;
        int                delta;
        int                lim;
        int                next_duty;
        int unsigned       quot;
        int unsigned       cmp_calc;
        logic [TIME_W-1:0] since;
        st.used = 1'b0;
        case (ev.kind)
            KIND_CAPTURE: begin
                if (ev.pwm > gate_cfg && ev.pwm < compare_now) begin
                    if (!capture_armed) begin
                        capture_armed = 1'b1;
                    end else begin
                        if (ev.capture > last_capture)
                            elapsed = int'(ev.capture) - int'(last_capture);
                        else
                            elapsed = int'(CAPTURE_PERIOD_DEF) - int'(last_capture)
                                      + int'(ev.capture);
                        // an elapsed count that is not positive gives no measurement
                        if (elapsed > 0) begin
                            quot = (CAPTURE_PERIOD_DEF * SEC_PER_MIN) / elapsed;
                            speed_now = SPEED_W'((quot > SPEED_SAT) ? SPEED_SAT : quot);
                            st.used = 1'b1;
                        end
                    end
                    last_capture = ev.capture;
                end else begin
                    capture_armed = 1'b0;
                end
            end
            KIND_BUTTON: begin
                since = ev.now - press_ms;
                if (since > hold_cfg) begin
                    if (!ev.down) begin
                        if (int'(target_now) + int'(step_cfg) <= int'(smax_cfg))
                            target_now = target_now + step_cfg;
                    end else if (target_now >= step_cfg) begin
                        target_now = target_now - step_cfg;
                    end
                    press_ms = ev.now;
                end
            end
            KIND_TICK: begin
                err       = int'(target_now) - int'(speed_now);
                divisor   = (gain_cfg == 0) ? 1 : int'(gain_cfg);
                delta     = err / divisor;
                lim       = (dmax_cfg > DUTY_LIMIT) ? int'(DUTY_LIMIT) : int'(dmax_cfg);
                next_duty = int'(duty_now) + delta;
                if (next_duty < 0)
                    next_duty = 0;
                else if (next_duty > lim)
                    next_duty = lim;
                duty_now    = DUTY_W'(next_duty);
                cmp_calc    = (PWM_PERIOD_DEF * next_duty) / PERCENT;
                compare_now = CMP_W'((cmp_calc > CMP_SAT) ? CMP_SAT : cmp_calc);
            end
            default: begin
            end
        endcase
        st.speed   = speed_now;
        st.target  = target_now;
        st.duty    = duty_now;
        st.compare = compare_now;
        return st;
    endfunction

    task automatic send_word(input fan_event_t ev, input logic typed, input fan_status_t typed_st);
        int          gap;
        fan_status_t predicted;
        gap = pick_gap(tx_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_kind          <= ev.kind;
        s_capture_value <= ev.capture;
        s_pwm_count     <= ev.pwm;
        s_button_down   <= ev.down;
        s_now_ms        <= ev.now;
        do @(posedge aclk); while (!s_ready);
        predicted = regulate_fan(ev);
        pending_status.push_back(typed ? typed_st : predicted);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] kept;
        case (idx)
            REG_GATE_THRESHOLD: begin gate_cfg = value[PWM_W-1:0];    kept = DATA_W'(gate_cfg); end
            REG_SPEED_MAX:      begin smax_cfg = value[TARGET_W-1:0]; kept = DATA_W'(smax_cfg); end
            REG_SPEED_STEP:     begin step_cfg = value[STEP_W-1:0];   kept = DATA_W'(step_cfg); end
            REG_HOLDOFF_MS:     begin hold_cfg = value[HOLD_W-1:0];   kept = DATA_W'(hold_cfg); end
            REG_GAIN_DIVISOR:   begin gain_cfg = value[GAIN_W-1:0];   kept = DATA_W'(gain_cfg); end
            REG_DUTY_MAX:       begin dmax_cfg = value[DUTY_W-1:0];   kept = DATA_W'(dmax_cfg); end
            default:            kept = '0;
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        // read back the same register
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== kept) begin
            $display("%0t register %0d read expected %0d actual %0d", $time, idx, kept, prdata);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want !== got) begin
            $display("%0t %s expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    initial begin : result_drain
        int gap;
        @(posedge aclk);
        forever begin
            gap = pick_gap(rx_calm);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    always @(posedge aclk) begin : status_check
        fan_status_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_status.size() == 0) begin
                $display("%0t unexpected result word: speed %0d target %0d duty %0d",
                         $time, m_measured_speed, m_target_speed, m_duty_percent);
                mismatches++;
            end else begin
                want = pending_status.pop_front();
                check_field("measured_speed", want.speed, m_measured_speed);
                check_field("target_speed", want.target, m_target_speed);
                check_field("duty_percent", want.duty, m_duty_percent);
                check_field("pwm_compare", want.compare, m_pwm_compare);
                check_field("capture_used", want.used, m_capture_used);
            end
        end
    end

    initial begin : stimulus
        fan_event_t        ev;
        cfg_set_t          set;
        logic [TIME_W-1:0] ms_clock;
        int                pick;
        ms_clock = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED[i])
            send_word(DIRECTED[i].ev, DIRECTED[i].typed, DIRECTED[i].status);

        for (int ph = 0; ph < N_SETS; ph++) begin
            // settings change only once every result is back
            s_valid <= 1'b0;
            while (pending_status.size() != 0) @(posedge aclk);
            set = CFG_SETS[ph];
            if (ph == RANDOM_SET) begin
                set.gate = PWM_W'($urandom_range(0, 1023));
                set.smax = TARGET_W'($urandom_range(0, 16383));
                set.step = STEP_W'($urandom_range(1, 4095));
                set.hold = HOLD_W'($urandom_range(0, 65535));
                set.gain = GAIN_W'($urandom_range(1, 65535));
                set.dmax = DUTY_W'($urandom_range(0, 127));
            end
            cfg_write(REG_GATE_THRESHOLD, DATA_W'(set.gate));
            cfg_write(REG_SPEED_MAX, DATA_W'(set.smax));
            cfg_write(REG_SPEED_STEP, DATA_W'(set.step));
            cfg_write(REG_HOLDOFF_MS, DATA_W'(set.hold));
            cfg_write(REG_GAIN_DIVISOR, DATA_W'(set.gain));
            cfg_write(REG_DUTY_MAX, DATA_W'(set.dmax));

            repeat (WORDS_PER_PHASE) begin
                pick = $urandom_range(0, 99);
                if (pick < 4)
                    ev.kind = KIND_UNKNOWN;
                else if (pick < 48)
                    ev.kind = KIND_CAPTURE;
                else if (pick < 74)
                    ev.kind = KIND_BUTTON;
                else
                    ev.kind = KIND_TICK;
                ev.capture = ($urandom_range(0, 9) == 0) ? CAP_W'($urandom_range(3000, 4095))
                                                         : CAP_W'($urandom_range(0, 2999));
                ev.pwm  = PWM_W'($urandom_range(0, 1023));
                ev.down = 1'($urandom_range(0, 1));
                ev.now  = $urandom();
                // most captures land inside the counting window when it is open
                if (ev.kind == KIND_CAPTURE && int'(gate_cfg) + 1 < int'(compare_now)
                        && $urandom_range(0, 99) < 85)
                    ev.pwm = PWM_W'($urandom_range(int'(gate_cfg) + 1, int'(compare_now) - 1));
                if (ev.kind == KIND_BUTTON) begin
                    if ($urandom_range(0, 4) == 0)
                        ms_clock = $urandom();
                    else
                        ms_clock = ms_clock + $urandom_range(0, 2 * int'(hold_cfg) + 2);
                    ev.now = ms_clock;
                end
                send_word(ev, 1'b0, '0);
            end
        end

        s_valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("[fan_speed_p_controller_core] OK");
        else
            $display("[fan_speed_p_controller_core] ERROR");
        $finish;
    end

endmodule

// File: sim.f
rtl/fsp_pkg.sv
rtl/fsp_serdiv.sv
rtl/fan_speed_p_controller_core.sv
tb/fan_speed_p_controller_core_test.sv
